/* rtl/core/open_address_hash_table_core_defines.svh */
// Assertion macros for the open-addressed hash table core.
// No dependencies; included by the top level.
`ifndef OPEN_ADDRESS_HASH_TABLE_CORE_DEFINES_SVH
`define OPEN_ADDRESS_HASH_TABLE_CORE_DEFINES_SVH

// same-cycle implication
`define OAHT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OAHT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/oaht_pkg.sv */
// Shared types, constants and the quadratic probe rank function for the hash table core.
// No dependencies.
package oaht_pkg;

  localparam int NUM_W           = 34;
  localparam int STATUS_W        = 2;
  localparam int SLOT_OUT_W      = 4;
  localparam int MAX_SLOTS       = 64;
  localparam int DEF_TABLE_SLOTS = 16;
  localparam int MOD_STEP        = 8;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_FOUND     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  // control part of the probe item travelling along the chain
  typedef struct packed {
    logic vld;
    logic ins;
    logic quad;
    logic hit;
  } oaht_ctl_t;

  // lowest i with i*i mod n == d, or n when no such i exists
  function automatic int qrank_f(input int d, input int n);
    int   r;
    int   sq;
    logic fnd;
    r   = n;
    sq  = 0;
    fnd = 1'b0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      if (i < n) begin
        if (!fnd && sq == d) begin
          r   = i;
          fnd = 1'b1;
        end
        sq = sq + 2 * i + 1;
        if (sq >= n) sq = sq - n;
        if (sq >= n) sq = sq - n;
      end
    end
    return r;
  endfunction

endpackage

/* rtl/core/open_address_hash_table_core.sv */
// Open-addressed hash table of numbers with linear or quadratic probing on insert.
// done_o rises after an item is accepted, once the home slot is formed (eight bits of the
// number a cycle), the probe item has walked the row of registered slot cells and the result
// register is loaded. The result appears on status_o and slot_o for one cycle with done_o high
// and cannot be held off; busy_o drops in that same cycle, so a new item is accepted only
// once the previous one is through.
// The table is empty after reset, no clearing.
// Depends on oaht_pkg, oaht_mod, oaht_cell and open_address_hash_table_core_defines.svh.
`include "open_address_hash_table_core_defines.svh"

module open_address_hash_table_core import oaht_pkg::*; #(
  parameter int TableSlots = DEF_TABLE_SLOTS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic                  kind_i,
  input  logic [NUM_W-1:0]      number_i,
  input  logic                  quadratic_probe_i,
  output logic                  done_o,
  output logic [STATUS_W-1:0]   status_o,
  output logic [SLOT_OUT_W-1:0] slot_o
);

  localparam int SlotW = $clog2(TableSlots);
  localparam int RankW = $clog2(TableSlots + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_HASH = 3'b010,
    S_SCAN = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic             kind_q;
  logic             quad_q;
  logic [NUM_W-1:0] num_q;

  logic             accept;
  logic             hash_done;
  logic [SlotW-1:0] home;

  oaht_ctl_t        ctl_w  [TableSlots+1];
  logic [NUM_W-1:0] num_w  [TableSlots+1];
  logic [SlotW-1:0] home_w [TableSlots+1];
  logic [RankW-1:0] rank_w [TableSlots+1];
  logic [SlotW-1:0] slot_w [TableSlots+1];

  logic                  done_q;
  status_e               status_q, status_d;
  logic [SLOT_OUT_W-1:0] slot_q;
  logic                  wr_en_q;
  logic [SlotW-1:0]      wr_slot_q;
  oaht_ctl_t             tail;

  assign accept = start_i && !busy_o;
  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (accept)    state_d = S_HASH;
      S_HASH:  if (hash_done) state_d = S_SCAN;
      S_SCAN:  if (tail.vld)  state_d = S_IDLE;
      default:                state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      wr_en_q <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= tail.vld;
      wr_en_q <= tail.vld && tail.ins && tail.hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_i;
      quad_q <= quadratic_probe_i;
      num_q  <= number_i;
    end
    if (tail.vld) begin
      status_q  <= status_d;
      slot_q    <= tail.hit ? SLOT_OUT_W'(slot_w[TableSlots]) : '0;
      wr_slot_q <= slot_w[TableSlots];
    end
  end

  oaht_mod #(
    .TableSlots(TableSlots)
  ) u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(accept),
    .num_i  (number_i),
    .done_o (hash_done),
    .home_o (home)
  );

  // launch the probe item into the head of the row
  assign ctl_w[0]  = {hash_done, (kind_q == KIND_INSERT), quad_q, 1'b0};
  assign num_w[0]  = num_q;
  assign home_w[0] = home;
  assign rank_w[0] = RankW'(TableSlots);
  assign slot_w[0] = '0;

  for (genvar k = 0; k < TableSlots; k++) begin : g_cell
    oaht_cell #(
      .TableSlots(TableSlots),
      .CellIdx   (k)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (ctl_w[k]),
      .num_i    (num_w[k]),
      .home_i   (home_w[k]),
      .rank_i   (rank_w[k]),
      .slot_i   (slot_w[k]),
      .wr_en_i  (wr_en_q),
      .wr_slot_i(wr_slot_q),
      .wr_num_i (num_q),
      .ctl_o    (ctl_w[k+1]),
      .num_o    (num_w[k+1]),
      .home_o   (home_w[k+1]),
      .rank_o   (rank_w[k+1]),
      .slot_o   (slot_w[k+1])
    );
  end

  assign tail = ctl_w[TableSlots];

  always_comb begin
    if (tail.ins) status_d = tail.hit ? ST_INSERTED : ST_OVERFLOW;
    else          status_d = tail.hit ? ST_FOUND : ST_NOT_FOUND;
  end

  assign done_o   = done_q;
  assign status_o = status_q;
  assign slot_o   = slot_q;

  `OAHT_ASSERT_IMP(a_done_idle, clk_i, rst_ni, done_q, state_q == S_IDLE, "result while busy")
  `OAHT_ASSERT_IMP(a_tail_scan, clk_i, rst_ni, tail.vld, state_q == S_SCAN, "stray probe item")
  `OAHT_ASSERT_IMP(a_launch_hash, clk_i, rst_ni, hash_done, state_q == S_HASH, "stray home slot")
  `OAHT_ASSERT_IMP(a_write_ins, clk_i, rst_ni, wr_en_q, done_q && status_q == ST_INSERTED, "bad write")

endmodule

/* rtl/core/oaht_mod.sv */
// Home slot unit: number mod slot count, MOD_STEP bits per cycle.
// Depends on oaht_pkg.
module oaht_mod import oaht_pkg::*; #(
  parameter int TableSlots = DEF_TABLE_SLOTS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [NUM_W-1:0]              num_i,
  output logic                          done_o,
  output logic [$clog2(TableSlots)-1:0] home_o
);

  localparam int SlotW = $clog2(TableSlots);
  localparam int Steps = (NUM_W + MOD_STEP - 1) / MOD_STEP;
  localparam int PadW  = Steps * MOD_STEP;
  localparam int CntW  = $clog2(Steps + 1);
  localparam logic [SlotW:0] NSlots = (SlotW + 1)'(TableSlots);

  logic [PadW-1:0]  sh_q, sh_d;
  logic [SlotW-1:0] r_q, r_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             done_q, done_d;

  always_comb begin
    logic [SlotW:0] r;
    r      = {1'b0, r_q};
    sh_d   = sh_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    r_d    = r_q;
    if (start_i) begin
      sh_d  = PadW'(num_i);
      r_d   = '0;
      cnt_d = CntW'(Steps);
    end else if (cnt_q != '0) begin
      for (int j = 0; j < MOD_STEP; j++) begin
        r = {r[SlotW-1:0], sh_q[PadW-1-j]};
        if (r >= NSlots) r = r - NSlots;
      end
      r_d    = r[SlotW-1:0];
      sh_d   = sh_q << MOD_STEP;
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
    r_q  <= r_d;
  end

  assign done_o = done_q;
  assign home_o = r_q;

endmodule

/* rtl/core/oaht_cell.sv */
// One table slot: holds its entry and updates the probe item passing through.
// Depends on oaht_pkg.
module oaht_cell import oaht_pkg::*; #(
  parameter int TableSlots = DEF_TABLE_SLOTS,
  parameter int CellIdx    = 0
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  oaht_ctl_t                       ctl_i,
  input  logic [NUM_W-1:0]                num_i,
  input  logic [$clog2(TableSlots)-1:0]   home_i,
  input  logic [$clog2(TableSlots+1)-1:0] rank_i,
  input  logic [$clog2(TableSlots)-1:0]   slot_i,
  input  logic                            wr_en_i,
  input  logic [$clog2(TableSlots)-1:0]   wr_slot_i,
  input  logic [NUM_W-1:0]                wr_num_i,
  output oaht_ctl_t                       ctl_o,
  output logic [NUM_W-1:0]                num_o,
  output logic [$clog2(TableSlots)-1:0]   home_o,
  output logic [$clog2(TableSlots+1)-1:0] rank_o,
  output logic [$clog2(TableSlots)-1:0]   slot_o
);

  localparam int SlotW = $clog2(TableSlots);
  localparam int RankW = $clog2(TableSlots + 1);
  localparam logic [SlotW:0]   KExt   = (SlotW + 1)'(CellIdx);
  localparam logic [SlotW:0]   NSlots = (SlotW + 1)'(TableSlots);
  localparam logic [SlotW-1:0] KIdx   = SlotW'(CellIdx);

  logic [RankW-1:0] qr_tab [TableSlots];

  for (genvar g = 0; g < TableSlots; g++) begin : g_qr
    assign qr_tab[g] = RankW'(qrank_f(g, TableSlots));
  end

  logic             valid_q;
  logic [NUM_W-1:0] entry_q;

  oaht_ctl_t        ctl_q, ctl_d;
  logic [NUM_W-1:0] num_q;
  logic [SlotW-1:0] home_q, slot_q, slot_d;
  logic [RankW-1:0] rank_q, rank_d;

  logic [SlotW:0]   gap_w;
  logic [SlotW-1:0] gap;
  logic [RankW-1:0] rank;
  logic             take;

  always_comb begin
    if ({1'b0, home_i} <= KExt) gap_w = KExt - {1'b0, home_i};
    else                        gap_w = KExt + NSlots - {1'b0, home_i};
    gap  = gap_w[SlotW-1:0];
    rank = ctl_i.quad ? qr_tab[gap] : RankW'(gap);

    if (ctl_i.ins) take = !valid_q && (rank < rank_i);
    else           take = !ctl_i.hit && valid_q && (entry_q == num_i);

    ctl_d  = ctl_i;
    rank_d = rank_i;
    slot_d = slot_i;
    if (ctl_i.vld && take) begin
      ctl_d.hit = 1'b1;
      rank_d    = rank;
      slot_d    = KIdx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      ctl_q   <= '0;
    end else begin
      if (wr_en_i && wr_slot_i == KIdx) valid_q <= 1'b1;
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_slot_i == KIdx) entry_q <= wr_num_i;
    num_q  <= num_i;
    home_q <= home_i;
    rank_q <= rank_d;
    slot_q <= slot_d;
  end

  assign ctl_o  = ctl_q;
  assign num_o  = num_q;
  assign home_o = home_q;
  assign rank_o = rank_q;
  assign slot_o = slot_q;

endmodule

/* bench/tb_open_address_hash_table_core.sv */
// Self-checking bench for open_address_hash_table_core: inserts and searches, checked
// against a mirror of the slot table kept in the bench. Depends on oaht_pkg and the RTL.
`timescale 1ns / 100ps

module tb_open_address_hash_table_core;
  import oaht_pkg::*;

  localparam int TABLE_SLOTS  = DEF_TABLE_SLOTS;
  localparam int RANDOM_ITEMS = 1200;
  localparam int LIMIT_CYCLES = 400000;
  localparam logic [NUM_W-1:0] NUM_MAX   = '1;
  localparam logic [NUM_W-1:0] TOP_PHONE = 34'd9999999999;

  typedef struct packed {
    status_e                status;
    logic [SLOT_OUT_W-1:0]  slot;
  } hash_result_t;

  class hash_table_mirror;
    bit               held[TABLE_SLOTS];
    logic [NUM_W-1:0] stored[TABLE_SLOTS];
    hash_result_t     awaited[$];
    int               errors = 0;

    task report(input string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    // updates the mirror and queues the outcome of one accepted item
    function void note_item(input logic kind, input logic [NUM_W-1:0] num, input logic quad);
      hash_result_t res;
      int           home;
      int           pos;
      res.slot = '0;
      if (kind == KIND_INSERT) begin
        res.status = ST_OVERFLOW;
        home = int'(num % TABLE_SLOTS);
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          pos = (home + (quad ? i * i : i)) % TABLE_SLOTS;
          if (!held[pos]) begin
            held[pos]   = 1'b1;
            stored[pos] = num;
            res.status  = ST_INSERTED;
            res.slot    = pos[SLOT_OUT_W-1:0];
            break;
          end
        end
      end else begin
        res.status = ST_NOT_FOUND;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          if (held[i] && stored[i] == num) begin
            res.status = ST_FOUND;
            res.slot   = i[SLOT_OUT_W-1:0];
            break;
          end
        end
      end
      awaited.push_back(res);
    endfunction

    task check_result(input logic [STATUS_W-1:0] status, input logic [SLOT_OUT_W-1:0] slot);
      hash_result_t want;
      if (awaited.size() == 0) begin
        report($sformatf("status %0d slot %0d with no item outstanding", status, slot));
        return;
      end
      want = awaited.pop_front();
      if (status !== want.status)
        report($sformatf("status %0d, expected %0d", status, want.status));
      if (slot !== want.slot)
        report($sformatf("slot %0d, expected %0d", slot, want.slot));
    endtask
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start_i;
  logic                  busy_o;
  logic                  kind_i;
  logic [NUM_W-1:0]      number_i;
  logic                  quadratic_probe_i;
  logic                  done_o;
  logic [STATUS_W-1:0]   status_o;
  logic [SLOT_OUT_W-1:0] slot_o;

  hash_table_mirror mirror;
  int               burst_left;

  open_address_hash_table_core #(
    .TableSlots(TABLE_SLOTS)
  ) u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .kind_i            (kind_i),
    .number_i          (number_i),
    .quadratic_probe_i (quadratic_probe_i),
    .done_o            (done_o),
    .status_o          (status_o),
    .slot_o            (slot_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && done_o) mirror.check_result(status_o, slot_o);
  end

  // bursts of items with random gaps between them
  task automatic send_item(input logic kind, input logic [NUM_W-1:0] num, input logic quad);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        start_i <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk_i);
      end
    end
    burst_left--;
    start_i           <= 1'b1;
    kind_i            <= kind;
    number_i          <= num;
    quadratic_probe_i <= quad;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    mirror.note_item(kind, num, quad);
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    while (mirror.awaited.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("FAIL open_address_hash_table_core");
    $finish;
  end

  initial begin
    logic             kind;
    logic             quad;
    logic [NUM_W-1:0] num;
    logic [63:0]      wide;
    int               pick;
    mirror            = new();
    burst_left        = 0;
    rst_ni            = 1'b0;
    start_i           = 1'b0;
    kind_i            = KIND_INSERT;
    number_i          = '0;
    quadratic_probe_i = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(KIND_SEARCH, '0, 1'b0);              // empty table
    send_item(KIND_INSERT, '0, 1'b0);
    send_item(KIND_INSERT, NUM_MAX, 1'b1);         // home 15
    send_item(KIND_INSERT, TOP_PHONE, 1'b0);       // linear wrap past slot 15
    send_item(KIND_INSERT, 34'd16, 1'b1);
    send_item(KIND_INSERT, 34'd32, 1'b1);
    send_item(KIND_INSERT, 34'd48, 1'b1);          // quadratic overflow with empty slots left
    send_item(KIND_SEARCH, 34'd48, 1'b0);
    send_item(KIND_SEARCH, 34'd16, 1'b1);          // probe bit ignored on search
    send_item(KIND_SEARCH, NUM_MAX, 1'b0);
    send_item(KIND_INSERT, '0, 1'b0);              // duplicate
    send_item(KIND_SEARCH, '0, 1'b1);              // lowest slot wins
    send_item(KIND_INSERT, 34'h2_AAAA_AAAA, 1'b0);
    send_item(KIND_SEARCH, 34'h1_5555_5555, 1'b0);
    send_item(KIND_INSERT, 34'd9, 1'b1);
    send_item(KIND_INSERT, 34'd7, 1'b1);
    drain_results();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 300 == 299) drain_results();
      wide = {$urandom, $urandom};
      case ($urandom_range(0, 6))
        0, 1, 2: num = wide[NUM_W-1:0];
        3:       num = NUM_W'($urandom_range(0, 255));
        4:       num = ($urandom_range(0, 1) != 0) ? NUM_MAX : TOP_PHONE;
        default: begin
          pick = $urandom_range(0, TABLE_SLOTS - 1);
          num  = mirror.held[pick] ? mirror.stored[pick] : wide[NUM_W-1:0];
        end
      endcase
      kind = ($urandom_range(0, 99) < 35) ? KIND_INSERT : KIND_SEARCH;
      quad = 1'($urandom_range(0, 1));
      send_item(kind, num, quad);
    end

    start_i <= 1'b0;
    while (mirror.awaited.size() != 0) @(posedge clk_i);
    repeat (TABLE_SLOTS + 16) @(posedge clk_i);
    if (mirror.errors == 0) begin
      $display("PASS open_address_hash_table_core");
    end else begin
      $display("FAIL open_address_hash_table_core");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/oaht_pkg.sv
rtl/core/oaht_mod.sv
rtl/core/oaht_cell.sv
rtl/core/open_address_hash_table_core.sv
bench/tb_open_address_hash_table_core.sv
